/* rtl/http_request_byte_parser_assert.svh */
// assertion macros shared by the rtl
// HRBP_ASSERT: same-cycle implication, HRBP_ASSERT_NEXT: next-cycle implication
`ifndef HTTP_REQUEST_BYTE_PARSER_ASSERT_SVH
`define HTTP_REQUEST_BYTE_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
`define HRBP_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("http request parser assertion failed");
`define HRBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("http request parser assertion failed");
`else
`define HRBP_ASSERT(label, clk, rst, ante, cons)
`define HRBP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/hrbp_pkg.sv */
`default_nettype none

package hrbp_pkg;

  // parse states
  localparam logic [4:0] ST_START        = 5'd0;
  localparam logic [4:0] ST_METHOD       = 5'd1;
  localparam logic [4:0] ST_BEFORE_URL   = 5'd2;
  localparam logic [4:0] ST_URL          = 5'd3;
  localparam logic [4:0] ST_BEFORE_QKEY  = 5'd4;
  localparam logic [4:0] ST_QKEY         = 5'd5;
  localparam logic [4:0] ST_BEFORE_QVAL  = 5'd6;
  localparam logic [4:0] ST_QVAL         = 5'd7;
  localparam logic [4:0] ST_BEFORE_PROTO = 5'd8;
  localparam logic [4:0] ST_PROTO        = 5'd9;
  localparam logic [4:0] ST_BEFORE_VER   = 5'd10;
  localparam logic [4:0] ST_VER          = 5'd11;
  localparam logic [4:0] ST_HKEY         = 5'd12;
  localparam logic [4:0] ST_BEFORE_HVAL  = 5'd13;
  localparam logic [4:0] ST_HVAL         = 5'd14;
  localparam logic [4:0] ST_CR           = 5'd15;
  localparam logic [4:0] ST_CRLF         = 5'd16;
  localparam logic [4:0] ST_CRLFCR       = 5'd17;
  localparam logic [4:0] ST_BODY         = 5'd18;
  localparam logic [4:0] ST_COMPLETE     = 5'd19;
  localparam logic [4:0] ST_INVALID      = 5'd20;

  // length value phases
  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_POS  = 2'd1;
  localparam logic [1:0] PH_NEG  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // field kinds
  localparam logic [3:0] KIND_NONE   = 4'd0;
  localparam logic [3:0] KIND_METHOD = 4'd1;
  localparam logic [3:0] KIND_URL    = 4'd2;
  localparam logic [3:0] KIND_QKEY   = 4'd3;
  localparam logic [3:0] KIND_QVAL   = 4'd4;
  localparam logic [3:0] KIND_PROTO  = 4'd5;
  localparam logic [3:0] KIND_VER    = 4'd6;
  localparam logic [3:0] KIND_HKEY   = 4'd7;
  localparam logic [3:0] KIND_HVAL   = 4'd8;
  localparam logic [3:0] KIND_BODY   = 4'd9;

  // request status
  localparam logic [1:0] STAT_RUNNING  = 2'd0;
  localparam logic [1:0] STAT_COMPLETE = 2'd1;
  localparam logic [1:0] STAT_INVALID  = 2'd2;

  // ascii bytes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [3:0] CL_LEN = 4'd14;

  typedef logic [7:0] byte_t;

  // characters of "Content-Length"
  function automatic byte_t cl_char(input logic [3:0] idx);
    byte_t ch;
    case (idx)
      4'd0:    ch = 8'h43;  // C
      4'd1:    ch = 8'h6F;  // o
      4'd2:    ch = 8'h6E;  // n
      4'd3:    ch = 8'h74;  // t
      4'd4:    ch = 8'h65;  // e
      4'd5:    ch = 8'h6E;  // n
      4'd6:    ch = 8'h74;  // t
      4'd7:    ch = 8'h2D;  // -
      4'd8:    ch = 8'h4C;  // L
      4'd9:    ch = 8'h65;  // e
      4'd10:   ch = 8'h6E;  // n
      4'd11:   ch = 8'h67;  // g
      4'd12:   ch = 8'h74;  // t
      4'd13:   ch = 8'h68;  // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

/* rtl/http_request_byte_parser.sv */
// channel  | handshake                   | payload
// ---------+-----------------------------+-----------------------------------------
// item     | item_valid / item_ready     | data_byte, first_byte, last_byte
// result   | result_valid / result_ready | byte_out, field_kind, field_end, status
//
// one item per cycle while item_ready is high; one registered result per item
// next state and result come from one level of decode on the current state and
// the byte, and load the parse state and the result register on the same edge
// item_ready is high while the result register is empty or being drained,
// so a stalled result stops new items only for as long as it is held
// rst (synchronous) and first_byte (for its own item) return to the start state
`default_nettype none
`include "http_request_byte_parser_assert.svh"

module http_request_byte_parser
  import hrbp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       first_byte,
  input  wire logic       last_byte,
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic [7:0]      byte_out,
  output logic [3:0]      field_kind,
  output logic            field_end,
  output logic [1:0]      status
);

  // parser state registers
  logic [4:0] parse_state;
  logic [3:0] key_pos;
  logic       key_ok;
  logic       len_seen;
  logic       len_pos;
  logic [1:0] len_phase;

  logic [4:0] parse_state_next;
  logic [3:0] key_pos_next;
  logic       key_ok_next;
  logic       len_seen_next;
  logic       len_pos_next;
  logic [1:0] len_phase_next;

  // starting point for this item: registers, or reset values on first_byte
  logic [4:0] cur_state;
  logic [3:0] cur_key_pos;
  logic       cur_key_ok;
  logic       cur_len_seen;
  logic       cur_len_pos;
  logic [1:0] cur_len_phase;

  // byte classes
  logic is_blank;
  logic is_upper;
  logic is_digit;
  logic is_crlf;

  // content-length key match and value tracking, computed for this byte
  logic       in_len_hdr;
  logic       key_hit;
  logic [3:0] key_step_pos;
  logic       key_step_ok;
  logic       val_pos;
  logic [1:0] val_phase;

  logic [3:0] kind;
  logic       fend;
  logic       accept;

  assign accept     = item_valid && item_ready;
  assign item_ready = !result_valid || result_ready;

  always_comb begin
    if (first_byte) begin
      cur_state     = ST_START;
      cur_key_pos   = '0;
      cur_key_ok    = 1'b1;
      cur_len_seen  = 1'b0;
      cur_len_pos   = 1'b0;
      cur_len_phase = PH_LEAD;
    end else begin
      cur_state     = parse_state;
      cur_key_pos   = key_pos;
      cur_key_ok    = key_ok;
      cur_len_seen  = len_seen;
      cur_len_pos   = len_pos;
      cur_len_phase = len_phase;
    end
  end

  assign is_blank = (data_byte == CH_SP) || (data_byte == CH_TAB);
  assign is_upper = (data_byte >= 8'h41) && (data_byte <= 8'h5A);
  assign is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
  assign is_crlf  = (data_byte == CH_CR) || (data_byte == CH_LF);

  assign in_len_hdr = cur_key_ok && (cur_key_pos == CL_LEN);

  // one step of the exact match against "Content-Length"
  assign key_hit = cur_key_ok && (cur_key_pos < CL_LEN) && (data_byte == cl_char(cur_key_pos));

  // key match step taken from a fresh key (first byte of a header line)
  logic fresh_hit;
  assign fresh_hit = (data_byte == cl_char(4'd0));

  always_comb begin
    key_step_pos = cur_key_pos;
    key_step_ok  = cur_key_ok;
    if (key_hit) begin
      key_step_pos = cur_key_pos + 4'd1;
    end else begin
      key_step_ok = 1'b0;
    end
  end

  // atoi-like sign and digit tracking of the length value
  always_comb begin
    val_pos   = cur_len_pos;
    val_phase = cur_len_phase;
    if (in_len_hdr) begin
      case (cur_len_phase)
        PH_LEAD: begin
          if (data_byte == CH_PLUS) begin
            val_phase = PH_POS;
          end else if (data_byte == CH_MINUS) begin
            val_phase = PH_NEG;
          end else if (is_digit) begin
            val_phase = PH_POS;
            if (data_byte != CH_ZERO) val_pos = 1'b1;
          end else begin
            val_phase = PH_DONE;
          end
        end
        PH_POS: begin
          if (is_digit) begin
            if (data_byte != CH_ZERO) val_pos = 1'b1;
          end else begin
            val_phase = PH_DONE;
          end
        end
        PH_NEG: begin
          if (!is_digit) val_phase = PH_DONE;
        end
        default: begin
        end
      endcase
    end
  end

  // main transition table
  always_comb begin
    parse_state_next = cur_state;
    key_pos_next     = cur_key_pos;
    key_ok_next      = cur_key_ok;
    len_seen_next    = cur_len_seen;
    len_pos_next     = cur_len_pos;
    len_phase_next   = cur_len_phase;
    kind             = KIND_NONE;
    fend             = 1'b0;
    case (cur_state)
      ST_START: begin
        if (is_crlf || is_blank) begin
        end else if (is_upper) begin
          parse_state_next = ST_METHOD;
          kind             = KIND_METHOD;
        end else begin
          parse_state_next = ST_INVALID;
        end
      end
      ST_METHOD: begin
        if (is_upper) begin
          kind = KIND_METHOD;
        end else if (is_blank) begin
          parse_state_next = ST_BEFORE_URL;
          fend             = 1'b1;
        end else begin
          parse_state_next = ST_INVALID;
        end
      end
      ST_BEFORE_URL: begin
        if (data_byte == CH_SLASH) begin
          parse_state_next = ST_URL;
          kind             = KIND_URL;
        end else if (!is_blank) begin
          parse_state_next = ST_INVALID;
        end
      end
      ST_URL: begin
        if (data_byte == CH_QMARK) begin
          parse_state_next = ST_BEFORE_QKEY;
          fend             = 1'b1;
        end else if (is_blank) begin
          parse_state_next = ST_BEFORE_PROTO;
          fend             = 1'b1;
        end else begin
          kind = KIND_URL;
        end
      end
      ST_BEFORE_QKEY: begin
        if (is_blank || is_crlf) begin
          parse_state_next = ST_INVALID;
        end else begin
          parse_state_next = ST_QKEY;
          kind             = KIND_QKEY;
        end
      end
      ST_QKEY: begin
        if (data_byte == CH_EQ) begin
          parse_state_next = ST_BEFORE_QVAL;
          fend             = 1'b1;
        end else if (is_blank) begin
          parse_state_next = ST_INVALID;
        end else begin
          kind = KIND_QKEY;
        end
      end
      ST_BEFORE_QVAL: begin
        if (is_blank || is_crlf) begin
          parse_state_next = ST_INVALID;
        end else begin
          parse_state_next = ST_QVAL;
          kind             = KIND_QVAL;
        end
      end
      ST_QVAL: begin
        if (data_byte == CH_AMP) begin
          parse_state_next = ST_BEFORE_QKEY;
          fend             = 1'b1;
        end else if (is_blank) begin
          parse_state_next = ST_BEFORE_PROTO;
          fend             = 1'b1;
        end else begin
          kind = KIND_QVAL;
        end
      end
      ST_BEFORE_PROTO: begin
        if (!is_blank) begin
          parse_state_next = ST_PROTO;
          kind             = KIND_PROTO;
        end
      end
      ST_PROTO: begin
        if (data_byte == CH_SLASH) begin
          parse_state_next = ST_BEFORE_VER;
          fend             = 1'b1;
        end else begin
          kind = KIND_PROTO;
        end
      end
      ST_BEFORE_VER: begin
        if (is_digit) begin
          parse_state_next = ST_VER;
          kind             = KIND_VER;
        end else begin
          parse_state_next = ST_INVALID;
        end
      end
      ST_VER: begin
        if (data_byte == CH_CR) begin
          parse_state_next = ST_CR;
          fend             = 1'b1;
        end else if (is_digit || (data_byte == CH_DOT)) begin
          kind = KIND_VER;
        end else begin
          parse_state_next = ST_INVALID;
        end
      end
      ST_HKEY: begin
        if (data_byte == CH_COLON) begin
          parse_state_next = ST_BEFORE_HVAL;
          fend             = 1'b1;
          // a later content-length header replaces the earlier one
          if (in_len_hdr) begin
            len_seen_next  = 1'b1;
            len_pos_next   = 1'b0;
            len_phase_next = PH_LEAD;
          end
        end else begin
          kind         = KIND_HKEY;
          key_pos_next = key_step_pos;
          key_ok_next  = key_step_ok;
        end
      end
      ST_BEFORE_HVAL: begin
        if (is_blank) begin
        end else if (data_byte == CH_CR) begin
          parse_state_next = ST_CR;
          fend             = 1'b1;
        end else begin
          parse_state_next = ST_HVAL;
          kind             = KIND_HVAL;
          len_pos_next     = val_pos;
          len_phase_next   = val_phase;
        end
      end
      ST_HVAL: begin
        if (data_byte == CH_CR) begin
          parse_state_next = ST_CR;
          fend             = 1'b1;
        end else begin
          kind           = KIND_HVAL;
          len_pos_next   = val_pos;
          len_phase_next = val_phase;
        end
      end
      ST_CR: begin
        if (data_byte == CH_LF) begin
          parse_state_next = ST_CRLF;
        end else begin
          parse_state_next = ST_INVALID;
        end
      end
      ST_CRLF: begin
        if (data_byte == CH_CR) begin
          parse_state_next = ST_CRLFCR;
        end else if (is_blank) begin
          parse_state_next = ST_INVALID;
        end else begin
          // new header key: restart the match at its first character
          parse_state_next = ST_HKEY;
          kind             = KIND_HKEY;
          key_pos_next     = fresh_hit ? 4'd1 : 4'd0;
          key_ok_next      = fresh_hit;
        end
      end
      ST_CRLFCR: begin
        if (data_byte == CH_LF) begin
          if (cur_len_seen) begin
            parse_state_next = cur_len_pos ? ST_BODY : ST_COMPLETE;
          end else begin
            parse_state_next = last_byte ? ST_COMPLETE : ST_BODY;
          end
        end else begin
          parse_state_next = ST_INVALID;
        end
      end
      ST_BODY: begin
        kind = KIND_BODY;
        if (last_byte) parse_state_next = ST_COMPLETE;
      end
      ST_COMPLETE: begin
      end
      default: begin
        // invalid state and any unused code
        parse_state_next = ST_INVALID;
      end
    endcase
  end

  // state registers advance only on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= ST_START;
      key_pos     <= '0;
      key_ok      <= 1'b1;
      len_seen    <= 1'b0;
      len_pos     <= 1'b0;
      len_phase   <= PH_LEAD;
    end else if (accept) begin
      parse_state <= parse_state_next;
      key_pos     <= key_pos_next;
      key_ok      <= key_ok_next;
      len_seen    <= len_seen_next;
      len_pos     <= len_pos_next;
      len_phase   <= len_phase_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_out   <= data_byte;
      field_kind <= kind;
      field_end  <= fend;
      if (parse_state_next == ST_COMPLETE) begin
        status <= STAT_COMPLETE;
      end else if (parse_state_next == ST_INVALID) begin
        status <= STAT_INVALID;
      end else begin
        status <= STAT_RUNNING;
      end
    end
  end

  // a closing delimiter never carries a field tag
  `HRBP_ASSERT(a_fend_untagged, clk, rst, result_valid && field_end, field_kind == KIND_NONE)
  // once complete only body bytes or untagged bytes come out
  `HRBP_ASSERT(a_complete_kind, clk, rst, result_valid && (status == STAT_COMPLETE),
               (field_kind == KIND_NONE) || (field_kind == KIND_BODY))
  // the state and key position registers never hold an unused code
  `HRBP_ASSERT(a_state_legal, clk, rst, 1'b1, (parse_state <= ST_INVALID) && (key_pos <= CL_LEN))
  // a positive length only follows a seen content-length header
  `HRBP_ASSERT(a_len_order, clk, rst, len_pos, len_seen)
  // every accepted item leaves a result behind
  `HRBP_ASSERT_NEXT(a_accept_result, clk, rst, accept, result_valid)

endmodule

`default_nettype wire

/* bench/http_request_byte_parser_test.sv */
module http_request_byte_parser_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hrbp_pkg::*;

  // run length and pacing
  localparam int RANDOM_ITEMS  = 900;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 8;      // the registered result, plus margin
  localparam int HOLD_CYCLES   = 40;     // long receiver hold-off
  localparam int PHASE_ITEMS   = 75;     // items per idling phase
  localparam int PRINT_LIMIT   = 100;

  // idling phases, walked in turn as items are accepted
  localparam int MODE_STEADY      = 0;
  localparam int MODE_SEND_GAPS   = 1;
  localparam int MODE_RECV_STALLS = 2;
  localparam int MODE_BOTH        = 3;

  // the one header key whose value is followed
  localparam logic [8*14-1:0] LEN_KEY = "Content-Length";

  // what the block says about one byte, apart from the byte itself
  typedef struct packed {
    logic [3:0] kind;
    logic       fend;
    logic [1:0] stat;
  } verdict_t;

  typedef struct packed {
    byte_t    b;
    verdict_t v;
  } tag_t;

  // one item on the input channel; typed rows carry their expected verdict
  typedef struct packed {
    byte_t    b;
    logic     first;
    logic     last;
    logic     typed;
    verdict_t v;
  } stream_byte_t;

  localparam verdict_t NO_VERDICT = '0;

  // directed rows: byte, first_byte, last_byte, typed, verdict
  localparam int DIRECTED_ROWS = 25;
  localparam stream_byte_t DIRECTED [DIRECTED_ROWS] = '{
    // top byte value where a method letter is due
    '{8'hFF,    1'b1, 1'b0, 1'b1, '{KIND_NONE,   1'b0, STAT_INVALID}},
    // invalid holds, last_byte ignored
    '{8'h00,    1'b0, 1'b1, 1'b1, '{KIND_NONE,   1'b0, STAT_INVALID}},
    // restart into a method
    '{"G",      1'b1, 1'b0, 1'b1, '{KIND_METHOD, 1'b0, STAT_RUNNING}},
    // blank closes the method, last_byte here means nothing
    '{CH_SP,    1'b0, 1'b1, 1'b1, '{KIND_NONE,   1'b1, STAT_RUNNING}},
    // leading blank ahead of the url stays out of the field
    '{CH_TAB,   1'b0, 1'b0, 1'b1, '{KIND_NONE,   1'b0, STAT_RUNNING}},
    '{CH_SLASH, 1'b0, 1'b0, 1'b1, '{KIND_URL,    1'b0, STAT_RUNNING}},
    // query with a key that starts with '=' and a value that starts with '&'
    '{CH_QMARK, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{CH_EQ,    1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{CH_EQ,    1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{CH_AMP,   1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{CH_SP,    1'b0, 1'b0, 1'b0, NO_VERDICT},
    // leading blank ahead of the protocol, then a high byte as protocol
    '{CH_TAB,   1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{8'h80,    1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{CH_SLASH, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{"9",      1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{CH_CR,    1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{CH_LF,    1'b0, 1'b0, 1'b0, NO_VERDICT},
    // blank line without a length header, not last: a body follows
    '{CH_CR,    1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{CH_LF,    1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{8'hFF,    1'b0, 1'b0, 1'b0, NO_VERDICT},
    // last body byte completes the request
    '{8'h00,    1'b0, 1'b1, 1'b1, '{KIND_BODY,   1'b0, STAT_COMPLETE}},
    // complete holds until a restart
    '{"X",      1'b0, 1'b0, 1'b1, '{KIND_NONE,   1'b0, STAT_COMPLETE}},
    // line breaks at the start are skipped
    '{CH_CR,    1'b1, 1'b0, 1'b1, '{KIND_NONE,   1'b0, STAT_RUNNING}},
    '{CH_LF,    1'b0, 1'b0, 1'b1, '{KIND_NONE,   1'b0, STAT_RUNNING}},
    // lower case cannot start a method
    '{"a",      1'b0, 1'b0, 1'b1, '{KIND_NONE,   1'b0, STAT_INVALID}}
  };

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel
  logic       item_valid = 1'b0;
  logic       item_ready;
  logic [7:0] data_byte  = '0;
  logic       first_byte = 1'b0;
  logic       last_byte  = 1'b0;

  // result channel
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic [7:0] byte_out;
  logic [3:0] field_kind;
  logic       field_end;
  logic [1:0] status;

  // bench state
  stream_byte_t byte_stream[$];      // every item to send, in order
  tag_t         expected_tags[$];    // predicted results not yet seen
  stream_byte_t offered;             // item on the input port right now
  tag_t         predicted;
  tag_t         want;
  int           next_pos       = 0;
  int           accepted_count = 0;
  int           results_seen   = 0;
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  logic         hold_off       = 1'b0;
  logic         fresh_request  = 1'b0;

  // predictor copy of the parser state
  logic [4:0] parse_st;
  logic [3:0] key_pos;
  logic       key_ok;
  logic       len_seen;
  logic       len_pos;
  logic [1:0] len_phase;

  http_request_byte_parser dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .data_byte    (data_byte),
    .first_byte   (first_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .byte_out     (byte_out),
    .field_kind   (field_kind),
    .field_end    (field_end),
    .status       (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic blank_char(input byte_t c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  function automatic logic upper_char(input byte_t c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic logic digit_char(input byte_t c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void clear_parser();
    parse_st  = ST_START;
    key_pos   = '0;
    key_ok    = 1'b1;
    len_seen  = 1'b0;
    len_pos   = 1'b0;
    len_phase = PH_LEAD;
  endfunction

  // whole key so far equals the length key
  function automatic logic on_length_key();
    return key_ok && key_pos == CL_LEN;
  endfunction

  // exact, case sensitive compare one key byte at a time
  function automatic void follow_key(input byte_t c);
    if (key_ok && key_pos < CL_LEN &&
        c == LEN_KEY[8*(int'(CL_LEN) - 1 - int'(key_pos)) +: 8])
      key_pos = key_pos + 4'd1;
    else
      key_ok = 1'b0;
  endfunction

  // sign, then digits: positive once a nonzero digit shows with no minus
  function automatic void follow_length(input byte_t c);
    if (!on_length_key()) return;
    case (len_phase)
      PH_LEAD: begin
        if (c == CH_PLUS) len_phase = PH_POS;
        else if (c == CH_MINUS) len_phase = PH_NEG;
        else if (digit_char(c)) begin
          len_phase = PH_POS;
          if (c != CH_ZERO) len_pos = 1'b1;
        end else len_phase = PH_DONE;
      end
      PH_POS: begin
        if (!digit_char(c)) len_phase = PH_DONE;
        else if (c != CH_ZERO) len_pos = 1'b1;
      end
      PH_NEG: begin
        if (!digit_char(c)) len_phase = PH_DONE;
      end
      default: ;
    endcase
  endfunction

  // tag one accepted byte and advance the parse state
  function automatic tag_t tag_byte(input byte_t c, input logic first, input logic last);
    tag_t       r;
    logic [4:0] nxt;
    if (first) clear_parser();
    r.b      = c;
    r.v.kind = KIND_NONE;
    r.v.fend = 1'b0;
    nxt      = parse_st;
    case (parse_st)
      ST_START: begin
        if (c == CH_CR || c == CH_LF || blank_char(c)) nxt = ST_START;
        else if (upper_char(c)) begin
          nxt = ST_METHOD;
          r.v.kind = KIND_METHOD;
        end else nxt = ST_INVALID;
      end
      ST_METHOD: begin
        if (upper_char(c)) r.v.kind = KIND_METHOD;
        else if (blank_char(c)) begin
          nxt = ST_BEFORE_URL;
          r.v.fend = 1'b1;
        end else nxt = ST_INVALID;
      end
      ST_BEFORE_URL: begin
        if (c == CH_SLASH) begin
          nxt = ST_URL;
          r.v.kind = KIND_URL;
        end else if (!blank_char(c)) nxt = ST_INVALID;
      end
      ST_URL: begin
        if (c == CH_QMARK) begin
          nxt = ST_BEFORE_QKEY;
          r.v.fend = 1'b1;
        end else if (blank_char(c)) begin
          nxt = ST_BEFORE_PROTO;
          r.v.fend = 1'b1;
        end else r.v.kind = KIND_URL;
      end
      ST_BEFORE_QKEY: begin
        if (blank_char(c) || c == CH_CR || c == CH_LF) nxt = ST_INVALID;
        else begin
          nxt = ST_QKEY;
          r.v.kind = KIND_QKEY;
        end
      end
      ST_QKEY: begin
        if (c == CH_EQ) begin
          nxt = ST_BEFORE_QVAL;
          r.v.fend = 1'b1;
        end else if (blank_char(c)) nxt = ST_INVALID;
        else r.v.kind = KIND_QKEY;
      end
      ST_BEFORE_QVAL: begin
        // first value byte is taken as is, even '&' or '='
        if (blank_char(c) || c == CH_CR || c == CH_LF) nxt = ST_INVALID;
        else begin
          nxt = ST_QVAL;
          r.v.kind = KIND_QVAL;
        end
      end
      ST_QVAL: begin
        if (c == CH_AMP) begin
          nxt = ST_BEFORE_QKEY;
          r.v.fend = 1'b1;
        end else if (blank_char(c)) begin
          nxt = ST_BEFORE_PROTO;
          r.v.fend = 1'b1;
        end else r.v.kind = KIND_QVAL;
      end
      ST_BEFORE_PROTO: begin
        if (!blank_char(c)) begin
          nxt = ST_PROTO;
          r.v.kind = KIND_PROTO;
        end
      end
      ST_PROTO: begin
        if (c == CH_SLASH) begin
          nxt = ST_BEFORE_VER;
          r.v.fend = 1'b1;
        end else r.v.kind = KIND_PROTO;
      end
      ST_BEFORE_VER: begin
        if (digit_char(c)) begin
          nxt = ST_VER;
          r.v.kind = KIND_VER;
        end else nxt = ST_INVALID;
      end
      ST_VER: begin
        if (c == CH_CR) begin
          nxt = ST_CR;
          r.v.fend = 1'b1;
        end else if (digit_char(c) || c == CH_DOT) r.v.kind = KIND_VER;
        else nxt = ST_INVALID;
      end
      ST_HKEY: begin
        if (c == CH_COLON) begin
          nxt = ST_BEFORE_HVAL;
          r.v.fend = 1'b1;
          // a later length header replaces the earlier value
          if (on_length_key()) begin
            len_seen  = 1'b1;
            len_pos   = 1'b0;
            len_phase = PH_LEAD;
          end
        end else begin
          r.v.kind = KIND_HKEY;
          follow_key(c);
        end
      end
      ST_BEFORE_HVAL: begin
        if (blank_char(c)) nxt = ST_BEFORE_HVAL;
        else if (c == CH_CR) begin
          nxt = ST_CR;
          r.v.fend = 1'b1;
        end else begin
          nxt = ST_HVAL;
          r.v.kind = KIND_HVAL;
          follow_length(c);
        end
      end
      ST_HVAL: begin
        if (c == CH_CR) begin
          nxt = ST_CR;
          r.v.fend = 1'b1;
        end else begin
          r.v.kind = KIND_HVAL;
          follow_length(c);
        end
      end
      ST_CR: begin
        nxt = (c == CH_LF) ? ST_CRLF : ST_INVALID;
      end
      ST_CRLF: begin
        if (c == CH_CR) nxt = ST_CRLFCR;
        else if (blank_char(c)) nxt = ST_INVALID;
        else begin
          nxt = ST_HKEY;
          r.v.kind = KIND_HKEY;
          key_pos = '0;
          key_ok  = 1'b1;
          follow_key(c);
        end
      end
      ST_CRLFCR: begin
        // blank line: length header decides, else last_byte does
        if (c != CH_LF) nxt = ST_INVALID;
        else if (len_seen) nxt = len_pos ? ST_BODY : ST_COMPLETE;
        else nxt = last ? ST_COMPLETE : ST_BODY;
      end
      ST_BODY: begin
        r.v.kind = KIND_BODY;
        if (last) nxt = ST_COMPLETE;
      end
      ST_COMPLETE: nxt = ST_COMPLETE;
      default:     nxt = ST_INVALID;
    endcase
    parse_st = nxt;
    if (nxt == ST_COMPLETE) r.v.stat = STAT_COMPLETE;
    else if (nxt == ST_INVALID) r.v.stat = STAT_INVALID;
    else r.v.stat = STAT_RUNNING;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic put(input byte_t b, input logic last);
    stream_byte_t it;
    it       = '0;
    it.b     = b;
    it.first = fresh_request;
    it.last  = last;
    fresh_request = 1'b0;
    byte_stream.push_back(it);
  endtask

  // ahead of the blank line last_byte is set now and then, it must not matter
  task automatic put_head(input byte_t b);
    put(b, $urandom_range(15) == 0);
  endtask

  task automatic put_text(input logic [8*16-1:0] txt, input int n);
    for (int i = 0; i < n; i++) put_head(txt[8*(n - 1 - i) +: 8]);
  endtask

  task automatic put_blanks(input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) put_head($urandom_range(1) ? CH_SP : CH_TAB);
  endtask

  function automatic byte_t word_char();
    if ($urandom_range(2) == 0) return byte_t'(CH_ZERO + $urandom_range(9));
    return byte_t'("a" + $urandom_range(25));
  endfunction

  // any url byte but blanks, controls and the query mark
  function automatic byte_t url_char();
    byte_t c;
    c = byte_t'($urandom_range(8'hFF, 8'h21));
    return (c == CH_QMARK) ? CH_DOT : c;
  endfunction

  task automatic put_digits(input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) put_head(byte_t'(CH_ZERO + $urandom_range(9)));
  endtask

  // one request, mostly well formed, with random content
  task automatic gen_request();
    int   start;
    int   n;
    logic len_hdr;
    logic len_positive;
    start        = byte_stream.size();
    len_hdr      = 1'b0;
    len_positive = 1'b0;
    fresh_request = 1'b1;

    // stray line breaks or blanks before the method
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(2, 1))
        case ($urandom_range(3))
          0:       put_head(CH_CR);
          1:       put_head(CH_LF);
          2:       put_head(CH_SP);
          default: put_head(CH_TAB);
        endcase

    // request line
    repeat ($urandom_range(5, 1)) put_head(byte_t'("A" + $urandom_range(25)));
    put_blanks(1, 2);
    put_head(CH_SLASH);
    repeat ($urandom_range(5)) put_head(url_char());
    if ($urandom_range(1)) begin
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) begin
        put_head(i == 0 ? CH_QMARK : CH_AMP);
        put_head($urandom_range(5) == 0 ? CH_AMP : word_char());
        repeat ($urandom_range(3)) put_head(word_char());
        put_head(CH_EQ);
        // value may open with '&' or '='
        case ($urandom_range(4))
          0:       put_head(CH_AMP);
          1:       put_head(CH_EQ);
          default: put_head(word_char());
        endcase
        repeat ($urandom_range(3)) put_head(word_char());
      end
    end
    put_blanks(1, 2);
    if ($urandom_range(3) != 0) put_text("HTTP", 4);
    else repeat ($urandom_range(4, 1)) put_head(byte_t'("A" + $urandom_range(25)));
    put_head(CH_SLASH);
    put_digits(1, 1);
    repeat ($urandom_range(3)) put_head($urandom_range(2) == 0 ? CH_DOT : word_char());
    put_head(CH_CR);
    put_head(CH_LF);

    // headers, the length key and near misses of it
    repeat ($urandom_range(3)) begin
      n = $urandom_range(5);
      case (n)
        0, 1:    put_text("Content-Length", 14);
        2:       put_text("Content-length", 14);
        3:       put_text("Content-Len", 11);
        4:       put_text("Content-Lengths", 15);
        default: repeat ($urandom_range(6, 1)) put_head(byte_t'("A" + $urandom_range(25)));
      endcase
      put_head(CH_COLON);
      put_blanks(0, 2);
      if (n <= 1) begin
        len_hdr = 1'b1;
        case ($urandom_range(4))
          0: begin
            // positive, maybe signed, padded or followed by junk
            if ($urandom_range(1)) put_head(CH_PLUS);
            if ($urandom_range(1)) put_head(CH_ZERO);
            put_head(byte_t'(CH_ZERO + $urandom_range(9, 1)));
            put_digits(0, 2);
            if ($urandom_range(2) == 0) put_head(byte_t'("a" + $urandom_range(25)));
            len_positive = 1'b1;
          end
          1: begin
            // zero, where a digit after junk does not count
            if ($urandom_range(1)) put_head(CH_PLUS);
            repeat ($urandom_range(3, 1)) put_head(CH_ZERO);
            if ($urandom_range(1)) begin
              put_head("x");
              put_head(byte_t'(CH_ZERO + $urandom_range(9, 1)));
            end
            len_positive = 1'b0;
          end
          2: begin
            put_head(CH_MINUS);
            put_digits(0, 3);
            len_positive = 1'b0;
          end
          3: begin
            // empty, a bare sign, or junk first
            case ($urandom_range(2))
              0: ;
              1: put_head(CH_PLUS);
              default: begin
                put_head(byte_t'("a" + $urandom_range(25)));
                put_digits(0, 2);
              end
            endcase
            len_positive = 1'b0;
          end
          default: begin
            // far past any counter width, still positive
            put_head(byte_t'(CH_ZERO + $urandom_range(9, 1)));
            put_digits(11, 19);
            len_positive = 1'b1;
          end
        endcase
      end else begin
        // blanks inside a value belong to it
        repeat ($urandom_range(6))
          put_head($urandom_range(4) == 0 ? CH_SP : word_char());
      end
      put_head(CH_CR);
      put_head(CH_LF);
    end

    // blank line, then a body where one is due
    put_head(CH_CR);
    if (len_hdr) begin
      put(CH_LF, 1'($urandom_range(1)));
      n = len_positive ? $urandom_range(5, 1) : 0;
    end else if ($urandom_range(1)) begin
      put(CH_LF, 1'b1);
      n = 0;
    end else begin
      put(CH_LF, 1'b0);
      n = $urandom_range(5, 1);
    end
    for (int i = 0; i < n; i++) put(byte_t'($urandom_range(255)), i == n - 1);

    // bytes after the end are ignored
    if ($urandom_range(4) == 0)
      repeat ($urandom_range(2, 1))
        put(byte_t'($urandom_range(255)), 1'($urandom_range(1)));

    // now and then one byte is broken
    if ($urandom_range(5) == 0)
      byte_stream[$urandom_range(byte_stream.size() - 1, start + 1)].b =
        byte_t'($urandom_range(255));
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(6, 1)) begin
      fresh_request = ($urandom_range(3) == 0);
      put(byte_t'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  task automatic build_stimulus();
    for (int i = 0; i < DIRECTED_ROWS; i++) byte_stream.push_back(DIRECTED[i]);
    while (byte_stream.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
      if ($urandom_range(4) == 0) gen_noise();
      else gen_request();
    end
  endtask

  // ---------------------------------------------------------------------------
  // idling
  // ---------------------------------------------------------------------------

  function automatic int idle_pct(input logic sender);
    case ((accepted_count / PHASE_ITEMS) % 4)
      MODE_SEND_GAPS:   return sender ? 55 : 0;
      MODE_RECV_STALLS: return sender ? 0 : 55;
      MODE_BOTH:        return 29;
      default:          return 0;
    endcase
  endfunction

  function automatic logic roll(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offers items, predicts each one at acceptance
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      clear_parser();
    end else begin
      if (item_valid && item_ready) begin
        predicted = tag_byte(offered.b, offered.first, offered.last);
        // typed rows stand on their own verdict
        if (offered.typed) predicted.v = offered.v;
        expected_tags.push_back(predicted);
        accepted_count <= accepted_count + 1;
      end
      // valid holds with a steady payload until the item is taken
      if (!item_valid || item_ready) begin
        if (next_pos < byte_stream.size() && !roll(idle_pct(1'b1))) begin
          offered = byte_stream[next_pos];
          next_pos++;
          item_valid <= 1'b1;
          data_byte  <= offered.b;
          first_byte <= offered.first;
          last_byte  <= offered.last;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: checks each result against the oldest prediction
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("mismatch: %s", what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_tags.size() == 0) begin
          flag_mismatch($sformatf("result %0d with nothing expected, byte %02h",
                                  results_seen, byte_out));
        end else begin
          want = expected_tags.pop_front();
          if (byte_out !== want.b)
            flag_mismatch($sformatf("result %0d byte_out %02h, expected %02h",
                                    results_seen, byte_out, want.b));
          if (field_kind !== want.v.kind)
            flag_mismatch($sformatf("result %0d field_kind %0d, expected %0d",
                                    results_seen, field_kind, want.v.kind));
          if (field_end !== want.v.fend)
            flag_mismatch($sformatf("result %0d field_end %0d, expected %0d",
                                    results_seen, field_end, want.v.fend));
          if (status !== want.v.stat)
            flag_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    results_seen, status, want.v.stat));
        end
        results_seen++;
      end
      result_ready <= !hold_off && !roll(idle_pct(1'b0));
    end
  end

  // one long hold-off early on, while the sender keeps offering,
  // so the result register fills and item_ready drops
  initial begin : long_hold
    int held;
    while (accepted_count < 30) @(posedge clk);
    hold_off <= 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_tags.size());
      $display("http_request_byte_parser_test failed");
      $finish;
    end
  end

  // main sequence
  initial begin
    build_stimulus();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (accepted_count < byte_stream.size()) @(posedge clk);
    while (expected_tags.size() != 0) @(posedge clk);
    // then drain, to catch a stray result
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("http_request_byte_parser_test passed");
    else
      $display("http_request_byte_parser_test failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/hrbp_pkg.sv
rtl/http_request_byte_parser.sv
bench/http_request_byte_parser_test.sv
